### hdl/tags_pkg.sv
// Shared types, constants and helpers of the time-aware gate scheduler.
// Used by tags_ctrl, tags_dp and time_aware_gate_scheduler.
`default_nettype none
package tags_pkg;

    localparam int TIME_W     = 40;
    localparam int CNT_W      = 32;
    localparam int HANDLE_W   = 16;
    localparam int CLS_W      = 3;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int FILL_W     = QPTR_W + 1;
    localparam int NCLASS     = 8;
    localparam int MAXSLOT    = 4;
    localparam int SLOT_W     = $clog2(MAXSLOT);
    localparam int DUR_W      = 32;
    localparam int CYC_W      = DUR_W + SLOT_W;
    localparam int MEM_AW     = CLS_W + QPTR_W;
    localparam int MEM_W      = HANDLE_W + 2 * TIME_W;
    localparam int TOT_W      = $clog2(NCLASS * QDEPTH) + 1;
    localparam int DIVC_W     = $clog2(TIME_W);
    localparam logic [CLS_W-1:0] TOP_CLASS = CLS_W'(NCLASS - 1);

    localparam logic [TIME_W-1:0] SLOT_RESET = 40'd1095216661480;

    typedef enum logic [1:0] {
        KIND_ENQ  = 2'd0,
        KIND_REL  = 2'd1,
        KIND_NONE = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        REG_SLOT_COUNT  = 4'd0,
        REG_SLOT_WORD0  = 4'd1,
        REG_SLOT_WORD1  = 4'd2,
        REG_SLOT_WORD2  = 4'd3,
        REG_SLOT_WORD3  = 4'd4,
        REG_BASE_DELAY  = 4'd5,
        REG_QUEUE_LIMIT = 4'd6,
        REG_CYCLE_START = 4'd7
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_ENQ, S_SUM, S_DIV, S_FIX, S_SLOT,
        S_SCAN_REQ, S_SCAN_CHK, S_EMIT_REQ, S_EMIT_OUT, S_NONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_ENQ, OP_SUM, OP_DIV, OP_FIX, OP_SLOT,
        OP_SCAN_REQ, OP_SCAN_CHK, OP_EMIT_REQ, OP_EMIT_OUT, OP_NONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic in_rel;
        logic sum_last;
        logic div_last;
        logic slot_hit;
        logic have_scan;
        logic have_emit;
        logic last_cls;
        logic elig_ok;
        logic out_free;
        logic total_zero;
    } t_stat;

    // zero duration acts as one
    function automatic logic [DUR_W-1:0] slot_dur(input logic [TIME_W-1:0] w);
        logic [DUR_W-1:0] d;
        d = w[DUR_W-1:0];
        return (d == '0) ? DUR_W'(1) : d;
    endfunction

endpackage
`default_nettype wire

### hdl/tags_ctrl.sv
// Sequencer of the gate scheduler: one state per phase of an item.
// Depends on tags_pkg; drives tags_dp by command, reads its status.
`default_nettype none
module tags_ctrl import tags_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = i_stat.in_rel ? S_SUM : S_ENQ;
            end
            S_ENQ:      if (i_stat.out_free) n_state = S_IDLE;
            S_SUM:      if (i_stat.sum_last) n_state = S_DIV;
            S_DIV:      if (i_stat.div_last) n_state = S_FIX;
            S_FIX:      n_state = S_SLOT;
            S_SLOT:     if (i_stat.slot_hit) n_state = S_SCAN_REQ;
            S_SCAN_REQ: begin
                if (i_stat.have_scan) n_state = S_SCAN_CHK;
                else if (i_stat.last_cls) n_state = S_EMIT_REQ;
            end
            S_SCAN_CHK: begin
                if (i_stat.elig_ok || !i_stat.last_cls) n_state = S_SCAN_REQ;
                else n_state = S_EMIT_REQ;
            end
            S_EMIT_REQ: begin
                if (i_stat.have_emit) n_state = S_EMIT_OUT;
                else if (i_stat.last_cls) n_state = i_stat.total_zero ? S_NONE : S_IDLE;
            end
            S_EMIT_OUT: if (i_stat.out_free) n_state = S_EMIT_REQ;
            S_NONE:     if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.in_ready = 1'b0;
        o_cmd.op       = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_valid) o_cmd.op = OP_LOAD;
            end
            S_ENQ:      if (i_stat.out_free) o_cmd.op = OP_ENQ;
            S_SUM:      o_cmd.op = OP_SUM;
            S_DIV:      o_cmd.op = OP_DIV;
            S_FIX:      o_cmd.op = OP_FIX;
            S_SLOT:     o_cmd.op = OP_SLOT;
            S_SCAN_REQ: o_cmd.op = OP_SCAN_REQ;
            S_SCAN_CHK: o_cmd.op = OP_SCAN_CHK;
            S_EMIT_REQ: o_cmd.op = OP_EMIT_REQ;
            S_EMIT_OUT: if (i_stat.out_free) o_cmd.op = OP_EMIT_OUT;
            S_NONE:     if (i_stat.out_free) o_cmd.op = OP_NONE;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

### hdl/tags_dp.sv
// Datapath of the gate scheduler: config registers, frame store, queue
// pointers, cycle remainder unit, counters and output register. Uses tags_pkg.
`default_nettype none
module tags_dp import tags_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  wire                  i_action,
    input  wire [HANDLE_W-1:0]   i_frame_handle,
    input  wire [7:0]            i_frame_priority,
    input  wire [TIME_W-1:0]     i_time_now,
    input  wire                  i_cfg_valid,
    input  wire [3:0]            i_cfg_index,
    input  wire [TIME_W-1:0]     i_cfg_data,
    input  wire                  i_ready,
    output logic                 o_valid,
    output logic [1:0]           o_result_kind,
    output logic                 o_enqueue_status,
    output logic [HANDLE_W-1:0]  o_out_handle,
    output logic [CLS_W-1:0]     o_out_priority,
    output logic [TIME_W-1:0]    o_arrival_time,
    output logic                 o_last_of_run,
    output logic [CNT_W-1:0]     o_accepted_total,
    output logic [CNT_W-1:0]     o_dropped_total,
    output logic [CNT_W-1:0]     o_released_total
);

    // configuration
    logic [2:0]        r_slot_count;
    logic [TIME_W-1:0] r_slot_word [MAXSLOT];
    logic [DUR_W-1:0]  r_base_delay;
    logic [3:0]        r_queue_limit;
    logic [TIME_W-1:0] r_cycle_start;

    // queue state
    logic [QPTR_W-1:0] r_head [NCLASS];
    logic [FILL_W-1:0] r_fill [NCLASS];
    logic [FILL_W-1:0] r_cnt  [NCLASS];
    logic [CNT_W-1:0]  r_acc, r_drop, r_rel;

    logic [MEM_W-1:0]  r_mem [NCLASS * QDEPTH];
    logic [MEM_W-1:0]  r_rd;

    // item working registers
    logic [HANDLE_W-1:0] r_handle;
    logic [CLS_W-1:0]    r_prio;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_abs;
    logic                r_neg;
    logic [CYC_W:0]      r_rem;
    logic [DIVC_W-1:0]   r_bit;
    logic [CYC_W-1:0]    r_cyc, r_pos, r_cur;
    logic [SLOT_W-1:0]   r_si;
    logic [NCLASS-1:0]   r_mask;
    logic [CLS_W-1:0]    r_cls;
    logic [FILL_W-1:0]   r_off;
    logic [TOT_W-1:0]    r_total, r_sent;
    logic                r_ovalid;

    logic [2:0]          used_slots;
    logic [SLOT_W-1:0]   last_si;
    logic [FILL_W-1:0]   lim;
    logic [TIME_W:0]     diff;
    logic [CYC_W:0]      rem_sh;
    logic [CYC_W-1:0]    cur_n;
    logic [DUR_W-1:0]    cur_dur;
    logic [TIME_W:0]     elig_sum;
    logic [TIME_W-1:0]   elig;
    logic [CLS_W-1:0]    in_prio;
    logic                full;
    logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
    logic                rd_en;
    logic [TIME_W-1:0]   rd_elig, rd_arr;
    logic [HANDLE_W-1:0] rd_handle;
    logic                out_free;
    logic                out_load;

    assign used_slots = (r_slot_count == 3'd0) ? 3'd1 :
                        (r_slot_count > 3'(MAXSLOT)) ? 3'(MAXSLOT) : r_slot_count;
    assign last_si    = SLOT_W'(used_slots - 3'd1);
    assign lim        = (r_queue_limit == 4'd0) ? FILL_W'(1) :
                        (r_queue_limit > 4'(QDEPTH)) ? FILL_W'(QDEPTH) :
                        FILL_W'(r_queue_limit);
    assign diff       = {1'b0, i_time_now} - {1'b0, r_cycle_start};
    assign rem_sh     = {r_rem[CYC_W-1:0], r_abs[TIME_W-1]};
    assign cur_dur    = slot_dur(r_slot_word[r_si]);
    assign cur_n      = r_cur + CYC_W'(cur_dur);
    assign elig_sum   = {1'b0, r_now} + {{(TIME_W-DUR_W+1){1'b0}}, r_base_delay};
    assign elig       = elig_sum[TIME_W] ? {TIME_W{1'b1}} : elig_sum[TIME_W-1:0];
    assign in_prio    = (i_frame_priority > 8'(TOP_CLASS)) ? TOP_CLASS
                                                           : i_frame_priority[CLS_W-1:0];
    assign full       = r_fill[r_prio] >= lim;
    assign wr_ptr     = r_head[r_prio] + r_fill[r_prio][QPTR_W-1:0];
    assign rd_ptr     = r_head[r_cls] + r_off[QPTR_W-1:0];
    assign {rd_handle, rd_arr, rd_elig} = r_rd;
    assign out_free   = !r_ovalid || i_ready;
    assign out_load   = (i_cmd.op == OP_ENQ) || (i_cmd.op == OP_EMIT_OUT) ||
                        (i_cmd.op == OP_NONE);

    assign o_stat.in_rel     = i_action;
    assign o_stat.sum_last   = r_si == last_si;
    assign o_stat.div_last   = r_bit == DIVC_W'(TIME_W - 1);
    assign o_stat.slot_hit   = (r_pos < cur_n) || (r_si == last_si);
    assign o_stat.have_scan  = r_mask[r_cls] && (r_off < r_fill[r_cls]);
    assign o_stat.have_emit  = r_off < r_cnt[r_cls];
    assign o_stat.last_cls   = r_cls == '0;
    assign o_stat.elig_ok    = rd_elig <= r_now;
    assign o_stat.out_free   = out_free;
    assign o_stat.total_zero = r_total == '0;

    assign rd_en = ((i_cmd.op == OP_SCAN_REQ) && o_stat.have_scan) ||
                   ((i_cmd.op == OP_EMIT_REQ) && o_stat.have_emit);

    // frame store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ENQ && !full) begin
            r_mem[{r_prio, wr_ptr}] <= {r_handle, r_now, elig};
        end
        if (rd_en) begin
            r_rd <= r_mem[{r_cls, rd_ptr}];
        end
    end

    // control state: config, queue pointers, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count  <= 3'd1;
            for (int i = 0; i < MAXSLOT; i++) r_slot_word[i] <= SLOT_RESET;
            r_base_delay  <= '0;
            r_queue_limit <= 4'(QDEPTH);
            r_cycle_start <= '0;
            for (int i = 0; i < NCLASS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
            r_acc    <= '0;
            r_drop   <= '0;
            r_rel    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_SLOT_COUNT:  r_slot_count   <= i_cfg_data[2:0];
                    REG_SLOT_WORD0:  r_slot_word[0] <= i_cfg_data;
                    REG_SLOT_WORD1:  r_slot_word[1] <= i_cfg_data;
                    REG_SLOT_WORD2:  r_slot_word[2] <= i_cfg_data;
                    REG_SLOT_WORD3:  r_slot_word[3] <= i_cfg_data;
                    REG_BASE_DELAY:  r_base_delay   <= i_cfg_data[DUR_W-1:0];
                    REG_QUEUE_LIMIT: r_queue_limit  <= i_cfg_data[3:0];
                    REG_CYCLE_START: r_cycle_start  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (i_cmd.op)
                OP_ENQ: begin
                    if (full) begin
                        r_drop <= r_drop + 1'b1;
                    end else begin
                        r_acc          <= r_acc + 1'b1;
                        r_fill[r_prio] <= r_fill[r_prio] + 1'b1;
                    end
                end
                OP_SCAN_CHK: if (o_stat.elig_ok) r_rel <= r_rel + 1'b1;
                OP_EMIT_REQ: begin
                    // retire the frames sent from this class
                    if (!o_stat.have_emit) begin
                        r_head[r_cls] <= r_head[r_cls] + r_cnt[r_cls][QPTR_W-1:0];
                        r_fill[r_cls] <= r_fill[r_cls] - r_cnt[r_cls];
                    end
                end
                default: ;
            endcase
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_handle <= i_frame_handle;
                r_prio   <= in_prio;
                r_now    <= i_time_now;
                r_neg    <= diff[TIME_W];
                r_abs    <= diff[TIME_W] ? TIME_W'(-diff) : diff[TIME_W-1:0];
                r_rem    <= '0;
                r_bit    <= '0;
                r_cyc    <= '0;
                r_si     <= '0;
            end
            OP_ENQ: begin
                o_result_kind    <= KIND_ENQ;
                o_enqueue_status <= full;
                o_out_handle     <= r_handle;
                o_out_priority   <= r_prio;
                o_arrival_time   <= r_now;
                o_last_of_run    <= 1'b1;
                o_accepted_total <= full ? r_acc : r_acc + 1'b1;
                o_dropped_total  <= full ? r_drop + 1'b1 : r_drop;
                o_released_total <= r_rel;
            end
            OP_SUM: begin
                r_cyc <= r_cyc + CYC_W'(cur_dur);
                r_si  <= r_si + 1'b1;
            end
            OP_DIV: begin
                // one remainder bit per cycle, MSB first
                r_rem <= (rem_sh >= {1'b0, r_cyc}) ? rem_sh - {1'b0, r_cyc} : rem_sh;
                r_abs <= {r_abs[TIME_W-2:0], 1'b0};
                r_bit <= r_bit + 1'b1;
            end
            OP_FIX: begin
                r_pos <= (r_neg && r_rem != '0) ? r_cyc - r_rem[CYC_W-1:0]
                                                : r_rem[CYC_W-1:0];
                r_si  <= '0;
                r_cur <= '0;
            end
            OP_SLOT: begin
                if (o_stat.slot_hit) begin
                    r_mask  <= r_slot_word[r_si][TIME_W-1:DUR_W];
                    r_cls   <= TOP_CLASS;
                    r_off   <= '0;
                    r_total <= '0;
                    r_sent  <= '0;
                end else begin
                    r_cur <= cur_n;
                    r_si  <= r_si + 1'b1;
                end
            end
            OP_SCAN_REQ: begin
                if (!o_stat.have_scan) begin
                    r_cnt[r_cls] <= r_off;
                    r_cls        <= r_cls - 1'b1;
                    r_off        <= '0;
                end
            end
            OP_SCAN_CHK: begin
                if (o_stat.elig_ok) begin
                    r_off   <= r_off + 1'b1;
                    r_total <= r_total + 1'b1;
                end else begin
                    r_cnt[r_cls] <= r_off;
                    r_cls        <= r_cls - 1'b1;
                    r_off        <= '0;
                end
            end
            OP_EMIT_REQ: begin
                if (!o_stat.have_emit) begin
                    r_cls <= r_cls - 1'b1;
                    r_off <= '0;
                end
            end
            OP_EMIT_OUT: begin
                o_result_kind    <= KIND_REL;
                o_enqueue_status <= 1'b0;
                o_out_handle     <= rd_handle;
                o_out_priority   <= r_cls;
                o_arrival_time   <= rd_arr;
                o_last_of_run    <= (r_sent + 1'b1) == r_total;
                o_accepted_total <= r_acc;
                o_dropped_total  <= r_drop;
                o_released_total <= r_rel;
                r_off            <= r_off + 1'b1;
                r_sent           <= r_sent + 1'b1;
            end
            OP_NONE: begin
                o_result_kind    <= KIND_NONE;
                o_enqueue_status <= 1'b0;
                o_out_handle     <= '0;
                o_out_priority   <= '0;
                o_arrival_time   <= '0;
                o_last_of_run    <= 1'b1;
                o_accepted_total <= r_acc;
                o_dropped_total  <= r_drop;
                o_released_total <= r_rel;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;

endmodule
`default_nettype wire

### hdl/time_aware_gate_scheduler.sv
// Top level of the time-aware gate scheduler: ties sequencer to datapath.
// Depends on tags_pkg, tags_ctrl and tags_dp.
//
//  channel   handshake              beat carries
//  input     i_valid / o_ready      action, frame handle, priority, time
//  result    o_valid / i_ready      kind, status, frame, counters, last
//  config    i_cfg_valid / o_cfg_ready   register index, write data
//
// Enqueue: the beat is registered on accept, then S_ENQ loads its result once
// the output is free. Release: the slot sum, the 40-step cycle remainder and
// the slot search, then a count pass over the classes and eligible frames and
// an emit pass over the classes and frames sent (or the nothing-found beat).
// The frame store's single read port reads one frame at a time. Reset is
// synchronous; queues come up empty, config at its defaults.
// A result waiting on the output does not block the next input beat, but
// holds the item that follows until the output frees.
`default_nettype none
module time_aware_gate_scheduler import tags_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire                  i_action,
    input  wire [HANDLE_W-1:0]   i_frame_handle,
    input  wire [7:0]            i_frame_priority,
    input  wire [TIME_W-1:0]     i_time_now,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [1:0]           o_result_kind,
    output logic                 o_enqueue_status,
    output logic [HANDLE_W-1:0]  o_out_handle,
    output logic [CLS_W-1:0]     o_out_priority,
    output logic [TIME_W-1:0]    o_arrival_time,
    output logic                 o_last_of_run,
    output logic [CNT_W-1:0]     o_accepted_total,
    output logic [CNT_W-1:0]     o_dropped_total,
    output logic [CNT_W-1:0]     o_released_total,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [3:0]            i_cfg_index,
    input  wire [TIME_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_ready     = cmd.in_ready;
    assign o_cfg_ready = 1'b1;

    tags_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tags_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_action         (i_action),
        .i_frame_handle   (i_frame_handle),
        .i_frame_priority (i_frame_priority),
        .i_time_now       (i_time_now),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_result_kind    (o_result_kind),
        .o_enqueue_status (o_enqueue_status),
        .o_out_handle     (o_out_handle),
        .o_out_priority   (o_out_priority),
        .o_arrival_time   (o_arrival_time),
        .o_last_of_run    (o_last_of_run),
        .o_accepted_total (o_accepted_total),
        .o_dropped_total  (o_dropped_total),
        .o_released_total (o_released_total)
    );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench of time_aware_gate_scheduler: directed and random
// frame traffic over several gate settings. Depends on tags_pkg and the RTL.
`timescale 1ns / 100ps

import tags_pkg::*;

typedef struct {
    logic [1:0]          kind;
    logic                status;
    logic [HANDLE_W-1:0] handle;
    logic [CLS_W-1:0]    prio;
    logic [TIME_W-1:0]   arrival;
    logic                last;
    logic [CNT_W-1:0]    acc;
    logic [CNT_W-1:0]    drp;
    logic [CNT_W-1:0]    rel;
} gate_result_t;

class gate_scoreboard;
    logic [2:0]          slot_cnt;
    logic [TIME_W-1:0]   slot_word [MAXSLOT];
    logic [31:0]         base_delay;
    logic [3:0]          qlimit;
    logic [TIME_W-1:0]   cstart;
    logic [HANDLE_W-1:0] hnd_mem  [NCLASS][QDEPTH];
    logic [TIME_W-1:0]   arr_mem  [NCLASS][QDEPTH];
    logic [TIME_W-1:0]   elig_mem [NCLASS][QDEPTH];
    int                  head     [NCLASS];
    int                  fill     [NCLASS];
    logic [CNT_W-1:0]    acc_cnt, drp_cnt, rel_cnt;
    gate_result_t        pending_q [$];
    int                  mismatches;
    int                  n_released, n_dropped, n_none;

    function new();
        slot_cnt = 1;
        foreach (slot_word[i]) slot_word[i] = SLOT_RESET;
        base_delay = 0;
        qlimit = 8;
        cstart = 0;
        foreach (head[i]) begin
            head[i] = 0;
            fill[i] = 0;
        end
        acc_cnt = 0;
        drp_cnt = 0;
        rel_cnt = 0;
        mismatches = 0;
        n_released = 0;
        n_dropped = 0;
        n_none = 0;
    endfunction

    function void set_reg(t_reg idx, logic [TIME_W-1:0] v);
        case (idx)
            REG_SLOT_COUNT:  slot_cnt = v[2:0];
            REG_SLOT_WORD0:  slot_word[0] = v;
            REG_SLOT_WORD1:  slot_word[1] = v;
            REG_SLOT_WORD2:  slot_word[2] = v;
            REG_SLOT_WORD3:  slot_word[3] = v;
            REG_BASE_DELAY:  base_delay = v[31:0];
            REG_QUEUE_LIMIT: qlimit = v[3:0];
            REG_CYCLE_START: cstart = v;
            default: ;
        endcase
    endfunction

    function longint gate_dur(int i);
        return (slot_word[i][31:0] == 0) ? 64'd1 : longint'(slot_word[i][31:0]);
    endfunction

    function logic [7:0] gate_mask(logic [TIME_W-1:0] now);
        int     n;
        longint cyc, pos, cursor;
        n = (slot_cnt < 1) ? 1 : (slot_cnt > MAXSLOT) ? MAXSLOT : int'(slot_cnt);
        cyc = 0;
        for (int i = 0; i < n; i++) cyc += gate_dur(i);
        pos = (longint'({24'd0, now}) - longint'({24'd0, cstart})) % cyc;
        if (pos < 0) pos += cyc;
        cursor = 0;
        for (int i = 0; i < n; i++) begin
            cursor += gate_dur(i);
            if (pos < cursor) return slot_word[i][39:32];
        end
        return slot_word[n-1][39:32];
    endfunction

    // note an accepted input beat and queue the results it must produce
    function void note_input(logic action, logic [HANDLE_W-1:0] h, logic [7:0] p,
                             logic [TIME_W-1:0] now);
        gate_result_t r, batch [$];
        int           c, lim, s;
        logic [TIME_W:0] sum;
        logic [7:0]   mask;
        if (action == 1'b0) begin
            c = (p > 7) ? 7 : int'(p);
            lim = (qlimit < 1) ? 1 : (qlimit > QDEPTH) ? QDEPTH : int'(qlimit);
            r.status = 0;
            if (fill[c] >= lim) begin
                drp_cnt++;
                r.status = 1;
                n_dropped++;
            end else begin
                s = (head[c] + fill[c]) % QDEPTH;
                sum = {1'b0, now} + {9'd0, base_delay};
                hnd_mem[c][s] = h;
                arr_mem[c][s] = now;
                elig_mem[c][s] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
                fill[c]++;
                acc_cnt++;
            end
            r.kind = KIND_ENQ;
            r.handle = h;
            r.prio = c[2:0];
            r.arrival = now;
            r.last = 1;
            r.acc = acc_cnt;
            r.drp = drp_cnt;
            r.rel = rel_cnt;
            pending_q = {pending_q, r};
            return;
        end
        mask = gate_mask(now);
        for (int k = 7; k >= 0; k--) begin
            if (!mask[k]) continue;
            while (fill[k] > 0 && elig_mem[k][head[k]] <= now) begin
                rel_cnt++;
                r.kind = KIND_REL;
                r.status = 0;
                r.handle = hnd_mem[k][head[k]];
                r.prio = k[2:0];
                r.arrival = arr_mem[k][head[k]];
                batch = {batch, r};
                head[k] = (head[k] + 1) % QDEPTH;
                fill[k]--;
                n_released++;
            end
        end
        if (batch.size() == 0) begin
            r.kind = KIND_NONE;
            r.status = 0;
            r.handle = 0;
            r.prio = 0;
            r.arrival = 0;
            batch = {batch, r};
            n_none++;
        end
        foreach (batch[j]) begin
            batch[j].acc = acc_cnt;
            batch[j].drp = drp_cnt;
            batch[j].rel = rel_cnt;
            batch[j].last = (j == batch.size() - 1);
            pending_q = {pending_q, batch[j]};
        end
    endfunction

    function void check_result(gate_result_t a);
        gate_result_t e;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: kind %0d handle %h", a.kind, a.handle);
            return;
        end
        e = pending_q.pop_front();
        if (a.kind !== e.kind || a.status !== e.status || a.handle !== e.handle ||
            a.prio !== e.prio || a.arrival !== e.arrival || a.last !== e.last ||
            a.acc !== e.acc || a.drp !== e.drp || a.rel !== e.rel) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp: kind %0d st %0d h %h p %0d arr %h last %0d cnt %0d/%0d/%0d",
                         e.kind, e.status, e.handle, e.prio, e.arrival, e.last,
                         e.acc, e.drp, e.rel);
                $display("         got: kind %0d st %0d h %h p %0d arr %h last %0d cnt %0d/%0d/%0d",
                         a.kind, a.status, a.handle, a.prio, a.arrival, a.last,
                         a.acc, a.drp, a.rel);
            end
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 1000000;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                i_valid = 0;
    logic                o_ready;
    logic                i_action = 0;
    logic [HANDLE_W-1:0] i_frame_handle = 0;
    logic [7:0]          i_frame_priority = 0;
    logic [TIME_W-1:0]   i_time_now = 0;
    logic                o_valid;
    logic                i_ready = 0;
    logic [1:0]          o_result_kind;
    logic                o_enqueue_status;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [CLS_W-1:0]    o_out_priority;
    logic [TIME_W-1:0]   o_arrival_time;
    logic                o_last_of_run;
    logic [CNT_W-1:0]    o_accepted_total, o_dropped_total, o_released_total;
    logic                i_cfg_valid = 0;
    logic                o_cfg_ready;
    logic [3:0]          i_cfg_index = 0;
    logic [TIME_W-1:0]   i_cfg_data = 0;

    gate_scoreboard      sb = new();
    logic [TIME_W-1:0]   clock_us;
    int                  cycles = 0;
    int                  stall_left = 0;
    int                  hold_left = 0;
    bit                  hold_request = 0;
    bit                  quiet = 0;
    int                  frames_sent = 0;
    int                  releases_sent = 0;

    time_aware_gate_scheduler u_top (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // result side: check each accepted beat, then pick the next ready level
    always @(posedge i_clk) begin
        gate_result_t a;
        if (i_rst_n && o_valid && i_ready) begin
            a.kind = o_result_kind;
            a.status = o_enqueue_status;
            a.handle = o_out_handle;
            a.prio = o_out_priority;
            a.arrival = o_arrival_time;
            a.last = o_last_of_run;
            a.acc = o_accepted_total;
            a.drp = o_dropped_total;
            a.rel = o_released_total;
            sb.check_result(a);
        end
        if (hold_request && hold_left == 0) begin
            hold_request = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 0;
        end else if (!quiet && $urandom_range(99) < 12) begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    function automatic logic [TIME_W-1:0] rand_time40();
        return {8'($urandom_range(0, 255)), 32'($urandom())};
    endfunction

    task automatic write_reg(t_reg idx, logic [TIME_W-1:0] v);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, v);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // drive one beat and hold it until taken; valid stays high on return
    task automatic send_beat(logic act, logic [HANDLE_W-1:0] h, logic [7:0] p,
                             logic [TIME_W-1:0] t);
        i_valid <= 1;
        i_action <= act;
        i_frame_handle <= h;
        i_frame_priority <= p;
        i_time_now <= t;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(act, h, p, t);
        if (act) releases_sent++;
        else frames_sent++;
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            i_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return;
        pause_sender(r < 94 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    endtask

    // drain everything, leaving the input idle
    task automatic settle();
        pause_sender(1);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic enq(logic [HANDLE_W-1:0] h, logic [7:0] p, logic [TIME_W-1:0] t);
        send_beat(1'b0, h, p, t);
    endtask

    task automatic rel(logic [TIME_W-1:0] t);
        send_beat(1'b1, '0, '0, t);
    endtask

    task automatic random_config(int style);
        logic [TIME_W-1:0] w;
        for (int i = 0; i < MAXSLOT; i++) begin
            case ($urandom_range(5))
                0:       w = {8'($urandom()), 32'd0};
                1:       w = {8'($urandom()), 32'($urandom())};
                default: w = {8'($urandom() | $urandom()), 32'($urandom_range(1, 40))};
            endcase
            if (style == 1) w = (i % 2) ? '0 : '1;
            write_reg(t_reg'(REG_SLOT_WORD0 + i), w);
        end
        write_reg(REG_SLOT_COUNT, style == 1 ? TIME_W'(7)
                  : style == 2 ? TIME_W'(0) : TIME_W'($urandom_range(1, 7)));
        write_reg(REG_QUEUE_LIMIT, style == 1 ? TIME_W'(15)
                  : style == 2 ? TIME_W'(0) : TIME_W'($urandom_range(0, 15)));
        write_reg(REG_BASE_DELAY, style == 1 ? TIME_W'(32'hFFFF_FFFF)
                  : TIME_W'($urandom_range(0, 30)));
        write_reg(REG_CYCLE_START, style == 1 ? {TIME_W{1'b1}}
                  : clock_us - TIME_W'($urandom_range(0, 100)));
    endtask

    task automatic random_traffic(int count);
        for (int n = 0; n < count; n++) begin
            random_gap();
            if ($urandom_range(19) == 0) clock_us = rand_time40();
            else clock_us += TIME_W'($urandom_range(0, 12));
            if ($urandom_range(99) < 55)
                enq(16'($urandom()),
                    ($urandom_range(7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7)),
                    clock_us);
            else
                rel(clock_us);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty release, priority clamp, field extremes, queue full
        rel('0);
        enq(16'h0000, 8'd0, 40'd0);
        enq(16'hFFFF, 8'd255, 40'd5);
        enq(16'h1234, 8'd8, 40'd6);
        enq(16'h5A5A, 8'd7, 40'd7);
        rel(40'd10);
        for (int i = 0; i < 9; i++) enq(16'(16'h300 + i), 8'd3, 40'(20 + i));
        rel({TIME_W{1'b1}});
        settle();

        // saturated eligible time, time before cycle start
        write_reg(REG_BASE_DELAY, 40'hFFFF_FFFF);
        write_reg(REG_CYCLE_START, 40'hFF_0000_0000);
        write_reg(REG_QUEUE_LIMIT, 40'd2);
        enq(16'hAAAA, 8'd1, 40'hFF_FFFF_FF00);
        enq(16'h5555, 8'd1, 40'd100);
        rel(40'd200);
        rel({TIME_W{1'b1}});
        settle();

        clock_us = 40'd1000;
        for (int ph = 0; ph < 6; ph++) begin
            random_config(ph == 1 ? 1 : ph == 3 ? 2 : 0);
            quiet = (ph == 4);
            if (ph == 2) begin
                hold_request = 1;
                for (int i = 0; i < 40; i++)
                    enq(16'($urandom()), 8'($urandom_range(0, 7)), clock_us);
                rel(clock_us + 40'd50);
            end
            random_traffic(65);
            settle();
        end
        quiet = 0;

        repeat (60) @(posedge i_clk);
        $display("covered %0d frame beats (%0d dropped) and %0d release beats",
                 frames_sent, sb.n_dropped, releases_sent);
        $display("released %0d frames, %0d releases found nothing, %0d mismatches",
                 sb.n_released, sb.n_none, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
